// ===== hw/rtl/itp_pkg.sv =====
// ============================================================================
// itp_pkg
// Shared types and constants for the ID3v2 text frame parser: frame
// identifiers, field codes, text encodings and the front-to-back queue item.
// ============================================================================
package itp_pkg;

    // Largest tag body accepted; longer tags end on their first byte
    localparam logic [28:0] MAX_TAG_BYTES = 29'd16777216;

    // Frame header geometry
    localparam logic [3:0]  HDR_IDENT_END = 4'd4;
    localparam logic [3:0]  HDR_SIZE_END  = 4'd8;
    localparam logic [3:0]  HDR_LEN       = 4'd10;
    localparam logic [7:0]  SYNCSAFE_VER  = 8'd4;

    // Configuration register indexes
    localparam logic CFG_MAJOR_VERSION = 1'b0;
    localparam logic CFG_TAG_LENGTH    = 1'b1;

    // Frame identifiers
    localparam logic [31:0] ID_TIT2 = 32'h5449_5432;
    localparam logic [31:0] ID_TPE1 = 32'h5450_4531;
    localparam logic [31:0] ID_TALB = 32'h5441_4C42;
    localparam logic [31:0] ID_TYER = 32'h5459_4552;
    localparam logic [31:0] ID_TDRC = 32'h5444_5243;
    localparam logic [31:0] ID_TCON = 32'h5443_4F4E;
    localparam logic [31:0] ID_TRCK = 32'h5452_434B;

    // Field codes
    localparam logic [2:0] FIELD_TITLE  = 3'd0;
    localparam logic [2:0] FIELD_ARTIST = 3'd1;
    localparam logic [2:0] FIELD_ALBUM  = 3'd2;
    localparam logic [2:0] FIELD_DATE   = 3'd3;
    localparam logic [2:0] FIELD_GENRE  = 3'd4;
    localparam logic [2:0] FIELD_TRACK  = 3'd5;

    // Text encodings
    localparam logic [7:0] ENC_LATIN1   = 8'd0;
    localparam logic [7:0] ENC_UTF16BOM = 8'd1;
    localparam logic [7:0] ENC_UTF16BE  = 8'd2;
    localparam logic [7:0] ENC_UTF8     = 8'd3;

    // Byte order marks and replacement character
    localparam logic [15:0] BOM_BE       = 16'hFEFF;
    localparam logic [15:0] BOM_LE       = 16'hFFFE;
    localparam logic [7:0]  CHAR_REPLACE = 8'h3F;

    // One queue entry: a body byte with its frame context, or a bare stop
    typedef struct packed {
        logic [7:0] data;
        logic       body;
        logic       first;
        logic       last;
        logic [2:0] field;
        logic       known;
        logic       done;
    } t_item;

    typedef struct packed {
        logic       known;
        logic [2:0] code;
    } t_lookup;

    // Map a frame identifier onto a text field
    function automatic t_lookup lookup_field(input logic [31:0] id);
        t_lookup res;
        res.known = 1'b1;
        res.code  = FIELD_TITLE;
        if (id == ID_TIT2) begin
            res.code = FIELD_TITLE;
        end else if (id == ID_TPE1) begin
            res.code = FIELD_ARTIST;
        end else if (id == ID_TALB) begin
            res.code = FIELD_ALBUM;
        end else if (id == ID_TYER || id == ID_TDRC) begin
            res.code = FIELD_DATE;
        end else if (id == ID_TCON) begin
            res.code = FIELD_GENRE;
        end else if (id == ID_TRCK) begin
            res.code = FIELD_TRACK;
        end else begin
            res.known = 1'b0;
        end
        return res;
    endfunction

endpackage

// ===== hw/rtl/itp_front.sv =====
// ============================================================================
// itp_front
// Accepts tag body bytes, walks the frame headers, tracks frame and tag
// bounds, and hands body bytes and stop events to the queue.
// ============================================================================
module itp_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [7:0]           i_data_byte,
    input  logic                 i_tag_start,
    input  logic [7:0]           i_major_version,
    input  logic [24:0]          i_tag_length,
    input  logic                 i_q_full,
    output logic                 o_push,
    output itp_pkg::t_item       o_item
);
    import itp_pkg::*;

    logic [24:0] r_consumed, n_consumed;
    logic [3:0]  r_hdr_idx,  n_hdr_idx;
    logic [31:0] r_ident,    n_ident;
    logic [31:0] r_size_acc, n_size_acc;
    logic [24:0] r_left,     n_left;
    logic [24:0] r_total,    n_total;
    logic [2:0]  r_field,    n_field;
    logic        r_known,    n_known;
    logic        r_in_body,  n_in_body;
    logic        r_stopped,  n_stopped;

    // Effective state after an optional tag_start clear
    logic [24:0] e_consumed;
    logic [3:0]  e_hdr_idx;
    logic [31:0] e_ident;
    logic [31:0] e_size_acc;
    logic        e_in_body;
    logic        e_stopped;

    logic        accept;
    logic        tag_oversize;
    logic        short_now;
    logic        short_next;
    logic [24:0] consumed_inc;
    logic [3:0]  hdr_idx_inc;
    logic [31:0] ident_new;
    logic [31:0] size_new;
    logic [31:0] size_val;
    logic [33:0] frame_end;
    logic [24:0] left_dec;
    logic        first_byte;
    logic        done;
    t_lookup     lk;

    assign o_ready = !i_q_full;
    assign accept  = i_valid && o_ready;

    assign e_consumed = i_tag_start ? '0 : r_consumed;
    assign e_hdr_idx  = i_tag_start ? '0 : r_hdr_idx;
    assign e_ident    = i_tag_start ? '0 : r_ident;
    assign e_size_acc = i_tag_start ? '0 : r_size_acc;
    assign e_in_body  = i_tag_start ? 1'b0 : r_in_body;
    assign e_stopped  = i_tag_start ? 1'b0 : r_stopped;

    // Fewer than a header's worth of bytes left in the tag
    assign tag_oversize = {4'b0, i_tag_length} > MAX_TAG_BYTES;
    assign consumed_inc = e_consumed + 25'd1;
    assign short_now    = tag_oversize ||
                          ({1'b0, e_consumed} + 26'd10 > {1'b0, i_tag_length});
    assign short_next   = tag_oversize ||
                          ({1'b0, consumed_inc} + 26'd10 > {1'b0, i_tag_length});

    // Header field assembly
    assign hdr_idx_inc = e_hdr_idx + 4'd1;
    assign ident_new   = (e_hdr_idx < HDR_IDENT_END) ? {e_ident[23:0], i_data_byte}
                                                      : e_ident;
    assign size_new    = (e_hdr_idx >= HDR_IDENT_END && e_hdr_idx < HDR_SIZE_END)
                         ? {e_size_acc[23:0], i_data_byte} : e_size_acc;

    // Syncsafe sizes OR whole bytes at 7-bit spacing
    always_comb begin
        if (i_major_version == SYNCSAFE_VER) begin
            size_val = {3'b0, size_new[31:24], 21'b0} |
                       {10'b0, size_new[23:16], 14'b0} |
                       {17'b0, size_new[15:8], 7'b0} |
                       {24'b0, size_new[7:0]};
        end else begin
            size_val = size_new;
        end
    end

    assign frame_end  = {9'b0, consumed_inc} + 34'd2 + {2'b0, size_val};
    assign left_dec   = r_left - 25'd1;
    assign first_byte = (r_left == r_total);
    assign lk         = lookup_field(e_ident);

    // Per-byte parse step
    always_comb begin
        n_consumed = r_consumed;
        n_hdr_idx  = r_hdr_idx;
        n_ident    = r_ident;
        n_size_acc = r_size_acc;
        n_left     = r_left;
        n_total    = r_total;
        n_field    = r_field;
        n_known    = r_known;
        n_in_body  = r_in_body;
        n_stopped  = r_stopped;
        done       = 1'b0;
        o_push     = 1'b0;

        o_item       = '0;
        o_item.data  = i_data_byte;
        o_item.field = r_field;
        o_item.known = r_known;

        if (accept) begin
            n_consumed = e_consumed;
            n_hdr_idx  = e_hdr_idx;
            n_ident    = e_ident;
            n_size_acc = e_size_acc;
            n_in_body  = e_in_body;
            n_stopped  = e_stopped;
            if (i_tag_start) begin
                n_left  = '0;
                n_total = '0;
                n_field = FIELD_TITLE;
                n_known = 1'b0;
            end

            if (e_stopped) begin
                // silent until the next tag
            end else if (!e_in_body) begin
                if (e_hdr_idx == '0 && short_now) begin
                    n_stopped = 1'b1;
                    done      = 1'b1;
                end else begin
                    n_ident    = ident_new;
                    n_size_acc = size_new;
                    n_consumed = consumed_inc;
                    n_hdr_idx  = hdr_idx_inc;
                    if (hdr_idx_inc == HDR_IDENT_END && ident_new == '0) begin
                        n_stopped = 1'b1;
                        done      = 1'b1;
                    end else if (hdr_idx_inc == HDR_SIZE_END) begin
                        if (size_val == '0 || frame_end > {9'b0, i_tag_length}) begin
                            n_stopped = 1'b1;
                            done      = 1'b1;
                        end else begin
                            n_total = size_val[24:0];
                        end
                    end else if (hdr_idx_inc >= HDR_LEN) begin
                        n_hdr_idx = '0;
                        n_in_body = 1'b1;
                        n_left    = r_total;
                        n_known   = lk.known && (r_total > 25'd1);
                        n_field   = lk.code;
                    end
                end
                o_push = done;
            end else begin
                // Frame body byte
                n_consumed   = consumed_inc;
                n_left       = left_dec;
                o_item.body  = 1'b1;
                o_item.first = first_byte;
                if (left_dec == '0) begin
                    o_item.last = 1'b1;
                    n_in_body   = 1'b0;
                    n_hdr_idx   = '0;
                    n_ident     = '0;
                    n_size_acc  = '0;
                    if (short_next) begin
                        n_stopped = 1'b1;
                        done      = 1'b1;
                    end
                end
                o_push = 1'b1;
            end
        end
        o_item.done = done;
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_consumed <= '0;
            r_hdr_idx  <= '0;
            r_ident    <= '0;
            r_size_acc <= '0;
            r_left     <= '0;
            r_total    <= '0;
            r_field    <= FIELD_TITLE;
            r_known    <= 1'b0;
            r_in_body  <= 1'b0;
            r_stopped  <= 1'b0;
        end else begin
            r_consumed <= n_consumed;
            r_hdr_idx  <= n_hdr_idx;
            r_ident    <= n_ident;
            r_size_acc <= n_size_acc;
            r_left     <= n_left;
            r_total    <= n_total;
            r_field    <= n_field;
            r_known    <= n_known;
            r_in_body  <= n_in_body;
            r_stopped  <= n_stopped;
        end
    end

endmodule

// ===== hw/rtl/itp_queue.sv =====
// ============================================================================
// itp_queue
// Small register queue between the header walker and the text decoder.
// ============================================================================
module itp_queue #(
    parameter int DEPTH = 4
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  itp_pkg::t_item i_item,
    input  logic           i_pop,
    output itp_pkg::t_item o_head,
    output logic           o_full,
    output logic           o_empty
);
    import itp_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_item         r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_count,  n_count;
    logic          do_push;
    logic          do_pop;

    assign o_full  = (r_count == FULL_CNT);
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_head  = r_mem[r_rd_ptr];

    // Pointer and occupancy update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + PW'(1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + PW'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + CW'(1);
        end else if (!do_push && do_pop) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

// ===== hw/rtl/itp_back.sv =====
// ============================================================================
// itp_back
// Decodes text bytes (pass-through or UTF-16 with byte order handling) and
// holds each result in an output register until it is taken.
// ============================================================================
module itp_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_empty,
    input  itp_pkg::t_item i_head,
    output logic           o_pop,
    output logic           o_valid,
    input  logic           i_ready,
    output logic [2:0]     o_field_code,
    output logic [7:0]     o_char_out,
    output logic           o_value_start,
    output logic           o_char_valid,
    output logic           o_value_end,
    output logic           o_parse_done
);
    import itp_pkg::*;

    logic [7:0] r_enc,     n_enc;
    logic [7:0] r_low,     n_low;
    logic       r_held,    n_held;
    logic       r_first_p, n_first_p;
    logic       r_be,      n_be;
    logic       r_null,    n_null;

    logic       r_valid,   n_valid;
    logic [2:0] r_field;
    logic [7:0] r_char;
    logic       r_vstart, r_cvalid, r_vend, r_done;

    logic       vstart, cvalid, vend, has_res;
    logic [7:0] ch;
    logic [15:0] pair_be;
    logic [15:0] code16;
    logic       skip;

    assign o_pop   = !i_q_empty && (!r_valid || i_ready);
    assign pair_be = {r_low, i_head.data};

    // Text decode of the head entry
    always_comb begin
        n_enc     = r_enc;
        n_low     = r_low;
        n_held    = r_held;
        n_first_p = r_first_p;
        n_be      = r_be;
        n_null    = r_null;
        vstart    = 1'b0;
        cvalid    = 1'b0;
        ch        = '0;
        skip      = 1'b0;
        code16    = r_be ? pair_be : {i_head.data, r_low};

        if (i_head.body) begin
            if (i_head.first) begin
                n_enc     = i_head.data;
                n_held    = 1'b0;
                n_first_p = 1'b1;
                n_be      = (i_head.data == ENC_UTF16BE);
                n_null    = 1'b0;
                vstart    = i_head.known;
            end else if (r_enc == ENC_LATIN1 || r_enc == ENC_UTF8) begin
                ch     = i_head.data;
                cvalid = i_head.known;
            end else if (!r_held) begin
                n_low  = i_head.data;
                n_held = 1'b1;
            end else begin
                n_held = 1'b0;
                // Byte order mark on the first pair of encoding 1
                if (r_first_p) begin
                    n_first_p = 1'b0;
                    if (r_enc == ENC_UTF16BOM) begin
                        if (pair_be == BOM_BE) begin
                            n_be = 1'b1;
                            skip = 1'b1;
                        end else if (pair_be == BOM_LE) begin
                            n_be = 1'b0;
                            skip = 1'b1;
                        end
                    end
                end
                if (!skip && !r_null) begin
                    if (code16 == '0) begin
                        n_null = 1'b1;
                    end else begin
                        ch     = (code16[15:8] == '0) ? code16[7:0] : CHAR_REPLACE;
                        cvalid = i_head.known;
                    end
                end
            end
        end
        vend    = i_head.body && i_head.last && i_head.known;
        has_res = vstart || cvalid || vend || i_head.done;
    end

    // Output register handshake
    always_comb begin
        if (o_pop && has_res) begin
            n_valid = 1'b1;
        end else if (r_valid && !i_ready) begin
            n_valid = 1'b1;
        end else begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= 1'b0;
            r_enc     <= '0;
            r_low     <= '0;
            r_held    <= 1'b0;
            r_first_p <= 1'b1;
            r_be      <= 1'b0;
            r_null    <= 1'b0;
        end else begin
            r_valid <= n_valid;
            if (o_pop) begin
                r_enc     <= n_enc;
                r_low     <= n_low;
                r_held    <= n_held;
                r_first_p <= n_first_p;
                r_be      <= n_be;
                r_null    <= n_null;
            end
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (o_pop && has_res) begin
            r_field  <= (vstart || cvalid || vend) ? i_head.field : FIELD_TITLE;
            r_char   <= cvalid ? ch : 8'd0;
            r_vstart <= vstart;
            r_cvalid <= cvalid;
            r_vend   <= vend;
            r_done   <= i_head.done;
        end
    end

    assign o_valid       = r_valid;
    assign o_field_code  = r_field;
    assign o_char_out    = r_char;
    assign o_value_start = r_vstart;
    assign o_char_valid  = r_cvalid;
    assign o_value_end   = r_vend;
    assign o_parse_done  = r_done;

endmodule

// ===== hw/rtl/id3v2_text_frame_parser.sv =====
// ============================================================================
// id3v2_text_frame_parser
// ID3v2 frame walker that reports the values of the common text frames.
// ============================================================================
// The block takes one tag body byte per clock and can accept a new byte every
// cycle while the queue has room; each result is registered first as a queue
// entry written by the header walker, then in the output register fed by the
// text decoder. The rate is set by the per-byte header step in the front,
// whose longest path is the frame size add and compare against the tag length,
// and by the decoder popping one queue entry per cycle while the output is not
// stalled. Input ready drops only while the queue is full, which happens only
// when the output side stalls. Configuration writes are taken at once and
// must be made while no byte is in flight.
module id3v2_text_frame_parser #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [24:0] i_cfg_data,
    // byte input
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_tag_start,
    // result output
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_field_code,
    output logic [7:0]  o_char_out,
    output logic        o_value_start,
    output logic        o_char_valid,
    output logic        o_value_end,
    output logic        o_parse_done
);
    import itp_pkg::*;

    logic [7:0]  r_major_version;
    logic [24:0] r_tag_length;
    logic        q_push, q_pop, q_full, q_empty;
    t_item       q_in, q_head;

    // Configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_major_version <= 8'd3;
            r_tag_length    <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_MAJOR_VERSION: r_major_version <= i_cfg_data[7:0];
                CFG_TAG_LENGTH:    r_tag_length    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    itp_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_data_byte     (i_data_byte),
        .i_tag_start     (i_tag_start),
        .i_major_version (r_major_version),
        .i_tag_length    (r_tag_length),
        .i_q_full        (q_full),
        .o_push          (q_push),
        .o_item          (q_in)
    );

    itp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (q_in),
        .i_pop   (q_pop),
        .o_head  (q_head),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    itp_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_empty     (q_empty),
        .i_head        (q_head),
        .o_pop         (q_pop),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_field_code  (o_field_code),
        .o_char_out    (o_char_out),
        .o_value_start (o_value_start),
        .o_char_valid  (o_char_valid),
        .o_value_end   (o_value_end),
        .o_parse_done  (o_parse_done)
    );

    // Checks
    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_full)
        else $error("queue push while full");

    a_no_empty_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_value_start && !o_char_valid && !o_value_end) |-> o_parse_done)
        else $error("result carries no flag");

    a_char_zero_when_unused: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_char_valid) |-> (o_char_out == 8'd0))
        else $error("char_out nonzero without char_valid");

    a_idle_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

endmodule
